FILE: hdl/pearson_correlation_stream_macros.svh
// Assertion macros for the Pearson correlation stream block.
`ifndef PEARSON_CORRELATION_STREAM_MACROS_SVH
`define PEARSON_CORRELATION_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCS_ASSERT_IMP(lbl, ante, cons, msg)
`define PCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/pcs_pkg.sv
// Types and constants shared by the Pearson correlation stream files.
package pcs_pkg;

    localparam int CORR_W  = 16;
    localparam int STAT_W  = 2;
    localparam int ROOT_W  = 17;
    localparam int RK_W    = $clog2(ROOT_W);
    localparam int Q_SHIFT = 2 * (ROOT_W - 1);
    localparam logic [ROOT_W-1:0] CORR_MAX = ROOT_W'(32767);

    typedef enum logic [1:0] {
        ST_VALID,
        ST_ZERO,
        ST_OVF
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_STORE,
        S_ROOT,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_XX,
        OP_YY,
        OP_XY,
        OP_NXX,
        OP_SXX,
        OP_NYY,
        OP_SYY,
        OP_NXY,
        OP_SXY,
        OP_MAG,
        OP_PRD
    } op_t;

endpackage

FILE: hdl/pcs_if.sv
// Valid/ready channel interfaces for sample pairs and correlation results.
interface pcs_pair_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_value;
    logic signed [SAMPLE_BITS-1:0] y_value;
    logic                          last_pair;

    modport source (output valid, x_value, y_value, last_pair, input ready);
    modport sink   (input valid, x_value, y_value, last_pair, output ready);
endinterface

interface pcs_result_if #(
    parameter int CNT_BITS = 13
);
    logic                       valid;
    logic                       ready;
    logic signed [15:0]         correlation;
    logic [1:0]                 status;
    logic [CNT_BITS-1:0]        pair_count;

    modport source (output valid, correlation, status, pair_count, input ready);
    modport sink   (input valid, correlation, status, pair_count, output ready);
endinterface

FILE: hdl/pearson_correlation_stream.sv
// Streaming Pearson correlation: serial multiplier, accumulators and bit-serial root search.
//
//  channel  | dir | payload                                  | beat
//  pairs    | in  | x_value, y_value (signed), last_pair     | valid & ready
//  result   | out | correlation (Q1.15), status, pair_count  | valid & ready
//
//  A pair takes 3 serial multiplies, one multiplier bit per cycle. A last pair adds up to 8
//  long multiplies (4 on zero variance) of up to CNT_W+SQW bits each, 17 root steps and an
//  emit step. Pairs past MAX_PAIRS are not multiplied and only set the overflow flag.
//  Reset clears sums, count and the output beat.
//  A pending result beat does not block new pairs; a second result waits for it.
`include "pearson_correlation_stream_macros.svh"

module pearson_correlation_stream #(
    parameter int MAX_PAIRS   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pcs_pair_if.sink     pairs,
    pcs_result_if.source result
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SW    = SAMPLE_BITS + CNT_W;
    localparam int SQW   = 2 * SAMPLE_BITS + CNT_W;
    localparam int VW    = CNT_W + SQW;
    localparam int PW    = 2 * VW;
    localparam int RW    = PW + pcs_pkg::Q_SHIFT + 3;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAIRS);

    pcs_pkg::state_t state_reg, state_next;
    pcs_pkg::op_t    op_reg, op_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SW-1:0]    sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [SQW-1:0]   sum_xx_reg, sum_xx_next, sum_yy_reg, sum_yy_next;
    logic signed [SQW-1:0]   sum_xy_reg, sum_xy_next;
    logic                    ovf_reg, ovf_next;
    logic                    zero_reg, zero_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]  x_reg, x_next, y_reg, y_next;
    logic                    last_reg, last_next;
    logic [PW-1:0]           mc_reg, mc_next, acc_reg, acc_next;
    logic [VW-1:0]           mp_reg, mp_next;
    logic                    mneg_reg, mneg_next;
    logic [VW:0]             tmp_reg, tmp_next;
    logic [VW-1:0]           va_reg, va_next, vb_reg, vb_next, cvm_reg, cvm_next;
    logic                    cvneg_reg, cvneg_next;
    logic [PW+pcs_pkg::Q_SHIFT-1:0] q_reg, q_next;
    logic [RW-1:0]           a_reg, a_next, bs_reg, bs_next, ps_reg, ps_next;
    logic [pcs_pkg::ROOT_W-1:0] m_reg, m_next;
    logic [pcs_pkg::RK_W-1:0]   k_reg, k_next;
    logic signed [pcs_pkg::CORR_W-1:0] corr_reg, corr_next;
    logic [pcs_pkg::STAT_W-1:0]        stat_reg, stat_next;
    logic [CNT_W-1:0]        pcnt_reg, pcnt_next;

    logic                    take, emit_go;
    logic [SAMPLE_BITS-1:0]  xm, ym;
    logic [SW-1:0]           sxm, sym;
    logic [SQW-1:0]          sxym;
    logic [VW-1:0]           op_a, op_b;
    logic                    op_neg;
    logic [PW:0]             prod_s;
    logic [VW:0]             diff;
    logic [RW-1:0]           root_t;
    logic                    root_fit;
    logic [pcs_pkg::ROOT_W:0]   m_inc;
    logic [pcs_pkg::ROOT_W-1:0] lo;
    logic [pcs_pkg::CORR_W-1:0] corr_pos;

    assign take = pairs.valid && pairs.ready;

    assign xm   = x_reg[SAMPLE_BITS-1] ? (~x_reg + 1'b1) : x_reg;
    assign ym   = y_reg[SAMPLE_BITS-1] ? (~y_reg + 1'b1) : y_reg;
    assign sxm  = sum_x_reg[SW-1] ? SW'(-sum_x_reg) : SW'(sum_x_reg);
    assign sym  = sum_y_reg[SW-1] ? SW'(-sum_y_reg) : SW'(sum_y_reg);
    assign sxym = sum_xy_reg[SQW-1] ? SQW'(-sum_xy_reg) : SQW'(sum_xy_reg);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (op_reg)
            pcs_pkg::OP_XX:
            begin
                op_a = VW'(xm);
                op_b = VW'(xm);
            end
            pcs_pkg::OP_YY:
            begin
                op_a = VW'(ym);
                op_b = VW'(ym);
            end
            pcs_pkg::OP_XY:
            begin
                op_a   = VW'(xm);
                op_b   = VW'(ym);
                op_neg = x_reg[SAMPLE_BITS-1] ^ y_reg[SAMPLE_BITS-1];
            end
            pcs_pkg::OP_NXX:
            begin
                op_a = VW'(count_reg);
                op_b = VW'(unsigned'(sum_xx_reg));
            end
            pcs_pkg::OP_SXX:
            begin
                op_a = VW'(sxm);
                op_b = VW'(sxm);
            end
            pcs_pkg::OP_NYY:
            begin
                op_a = VW'(count_reg);
                op_b = VW'(unsigned'(sum_yy_reg));
            end
            pcs_pkg::OP_SYY:
            begin
                op_a = VW'(sym);
                op_b = VW'(sym);
            end
            pcs_pkg::OP_NXY:
            begin
                op_a   = VW'(count_reg);
                op_b   = VW'(sxym);
                op_neg = sum_xy_reg[SQW-1];
            end
            pcs_pkg::OP_SXY:
            begin
                op_a   = VW'(sxm);
                op_b   = VW'(sym);
                op_neg = sum_x_reg[SW-1] ^ sum_y_reg[SW-1];
            end
            pcs_pkg::OP_MAG:
            begin
                op_a = cvm_reg;
                op_b = cvm_reg;
            end
            pcs_pkg::OP_PRD:
            begin
                op_a = va_reg;
                op_b = vb_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign prod_s   = mneg_reg ? (~{1'b0, acc_reg} + 1'b1) : {1'b0, acc_reg};
    assign diff     = tmp_reg - prod_s[VW:0];
    assign root_t   = a_reg + bs_reg + ps_reg;
    assign root_fit = root_t <= RW'(q_reg);
    assign m_inc    = {1'b0, m_reg} + 1'b1;
    assign lo       = m_inc[pcs_pkg::ROOT_W:1];
    assign corr_pos = (lo > pcs_pkg::CORR_MAX) ? pcs_pkg::CORR_W'(pcs_pkg::CORR_MAX)
                                               : lo[pcs_pkg::CORR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcs_pkg::S_IDLE:
            begin
                if (take)
                begin
                    if (count_reg < CNT_MAX)
                        state_next = pcs_pkg::S_LOAD;
                    else if (pairs.last_pair)
                        state_next = pcs_pkg::S_EMIT;
                end
            end
            pcs_pkg::S_LOAD:
                state_next = pcs_pkg::S_MUL;
            pcs_pkg::S_MUL:
            begin
                if (mp_reg == '0)
                    state_next = pcs_pkg::S_STORE;
            end
            pcs_pkg::S_STORE:
            begin
                case (op_reg)
                    pcs_pkg::OP_XY:
                        state_next = last_reg ? pcs_pkg::S_LOAD : pcs_pkg::S_IDLE;
                    pcs_pkg::OP_SYY:
                        state_next = (va_reg == '0 || diff[VW-1:0] == '0) ? pcs_pkg::S_EMIT
                                                                          : pcs_pkg::S_LOAD;
                    pcs_pkg::OP_PRD:
                        state_next = pcs_pkg::S_ROOT;
                    default:
                        state_next = pcs_pkg::S_LOAD;
                endcase
            end
            pcs_pkg::S_ROOT:
            begin
                if (k_reg == '0)
                    state_next = pcs_pkg::S_EMIT;
            end
            pcs_pkg::S_EMIT:
            begin
                if (emit_go)
                    state_next = pcs_pkg::S_IDLE;
            end
            default:
                state_next = pcs_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        pairs.ready = (state_reg == pcs_pkg::S_IDLE);
        emit_go     = (state_reg == pcs_pkg::S_EMIT) && (!out_valid_reg || result.ready);
    end

    assign result.valid       = out_valid_reg;
    assign result.correlation = corr_reg;
    assign result.status      = stat_reg;
    assign result.pair_count  = pcnt_reg;

    // datapath
    always_comb
    begin
        op_next        = op_reg;
        count_next     = count_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_xx_next    = sum_xx_reg;
        sum_yy_next    = sum_yy_reg;
        sum_xy_next    = sum_xy_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        acc_next       = acc_reg;
        mneg_next      = mneg_reg;
        tmp_next       = tmp_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        cvm_next       = cvm_reg;
        cvneg_next     = cvneg_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        bs_next        = bs_reg;
        ps_next        = ps_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        corr_next      = corr_reg;
        stat_next      = stat_reg;
        pcnt_next      = pcnt_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            pcs_pkg::S_IDLE:
            begin
                if (take)
                begin
                    last_next = pairs.last_pair;
                    if (count_reg < CNT_MAX)
                    begin
                        x_next     = pairs.x_value;
                        y_next     = pairs.y_value;
                        sum_x_next = sum_x_reg + SW'(pairs.x_value);
                        sum_y_next = sum_y_reg + SW'(pairs.y_value);
                        count_next = count_reg + 1'b1;
                        op_next    = pcs_pkg::OP_XX;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            pcs_pkg::S_LOAD:
            begin
                mc_next   = PW'(op_a);
                mp_next   = op_b;
                acc_next  = '0;
                mneg_next = op_neg;
            end
            pcs_pkg::S_MUL:
            begin
                if (mp_reg != '0)
                begin
                    if (mp_reg[0])
                        acc_next = acc_reg + mc_reg;
                    mc_next = mc_reg << 1;
                    mp_next = mp_reg >> 1;
                end
            end
            pcs_pkg::S_STORE:
            begin
                case (op_reg)
                    pcs_pkg::OP_XX:
                    begin
                        sum_xx_next = sum_xx_reg + SQW'(acc_reg);
                        op_next     = pcs_pkg::OP_YY;
                    end
                    pcs_pkg::OP_YY:
                    begin
                        sum_yy_next = sum_yy_reg + SQW'(acc_reg);
                        op_next     = pcs_pkg::OP_XY;
                    end
                    pcs_pkg::OP_XY:
                    begin
                        sum_xy_next = sum_xy_reg + prod_s[SQW-1:0];
                        op_next     = pcs_pkg::OP_NXX;
                    end
                    pcs_pkg::OP_NXX:
                    begin
                        tmp_next = prod_s[VW:0];
                        op_next  = pcs_pkg::OP_SXX;
                    end
                    pcs_pkg::OP_SXX:
                    begin
                        va_next = diff[VW-1:0];
                        op_next = pcs_pkg::OP_NYY;
                    end
                    pcs_pkg::OP_NYY:
                    begin
                        tmp_next = prod_s[VW:0];
                        op_next  = pcs_pkg::OP_SYY;
                    end
                    pcs_pkg::OP_SYY:
                    begin
                        vb_next   = diff[VW-1:0];
                        zero_next = (va_reg == '0) || (diff[VW-1:0] == '0);
                        op_next   = pcs_pkg::OP_NXY;
                    end
                    pcs_pkg::OP_NXY:
                    begin
                        tmp_next = prod_s[VW:0];
                        op_next  = pcs_pkg::OP_SXY;
                    end
                    pcs_pkg::OP_SXY:
                    begin
                        cvneg_next = diff[VW];
                        cvm_next   = diff[VW] ? VW'(~diff + 1'b1) : diff[VW-1:0];
                        op_next    = pcs_pkg::OP_MAG;
                    end
                    pcs_pkg::OP_MAG:
                    begin
                        q_next  = {acc_reg, pcs_pkg::Q_SHIFT'(0)};
                        op_next = pcs_pkg::OP_PRD;
                    end
                    pcs_pkg::OP_PRD:
                    begin
                        a_next  = '0;
                        bs_next = '0;
                        ps_next = RW'(acc_reg) << pcs_pkg::Q_SHIFT;
                        m_next  = '0;
                        k_next  = pcs_pkg::RK_W'(pcs_pkg::ROOT_W - 1);
                    end
                    default:
                    begin
                        op_next = pcs_pkg::OP_XX;
                    end
                endcase
            end
            pcs_pkg::S_ROOT:
            begin
                // test (m + 2^k)^2 * P against Q
                if (root_fit)
                begin
                    a_next  = root_t;
                    m_next  = m_reg | (pcs_pkg::ROOT_W'(1) << k_reg);
                    bs_next = (bs_reg >> 1) + ps_reg;
                end
                else
                begin
                    bs_next = bs_reg >> 1;
                end
                ps_next = ps_reg >> 2;
                if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            pcs_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    pcnt_next      = count_reg;
                    if (ovf_reg)
                    begin
                        stat_next = pcs_pkg::ST_OVF;
                        corr_next = '0;
                    end
                    else if (zero_reg)
                    begin
                        stat_next = pcs_pkg::ST_ZERO;
                        corr_next = '0;
                    end
                    else
                    begin
                        stat_next = pcs_pkg::ST_VALID;
                        corr_next = cvneg_reg ? signed'(-lo[pcs_pkg::CORR_W-1:0])
                                              : signed'(corr_pos);
                    end
                    count_next  = '0;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    sum_xx_next = '0;
                    sum_yy_next = '0;
                    sum_xy_next = '0;
                    ovf_next    = 1'b0;
                    zero_next   = 1'b0;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcs_pkg::S_IDLE;
            op_reg        <= pcs_pkg::OP_XX;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            sum_xy_reg    <= '0;
            ovf_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_xx_reg    <= sum_xx_next;
            sum_yy_reg    <= sum_yy_next;
            sum_xy_reg    <= sum_xy_next;
            ovf_reg       <= ovf_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        last_reg  <= last_next;
        mc_reg    <= mc_next;
        mp_reg    <= mp_next;
        acc_reg   <= acc_next;
        mneg_reg  <= mneg_next;
        tmp_reg   <= tmp_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        cvm_reg   <= cvm_next;
        cvneg_reg <= cvneg_next;
        q_reg     <= q_next;
        a_reg     <= a_next;
        bs_reg    <= bs_next;
        ps_reg    <= ps_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        corr_reg  <= corr_next;
        stat_reg  <= stat_next;
        pcnt_reg  <= pcnt_next;
    end

    `PCS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_MAX, "pair count past limit")
    `PCS_ASSERT_NXT(a_root_step, state_reg == pcs_pkg::S_ROOT && k_reg != '0,
        state_reg == pcs_pkg::S_ROOT && k_reg == $past(k_reg) - 1'b1, "root step skipped")
    `PCS_ASSERT_NXT(a_emit_hold, state_reg == pcs_pkg::S_EMIT && out_valid_reg && !result.ready,
        state_reg == pcs_pkg::S_EMIT && out_valid_reg, "pending result overwritten")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the streaming Pearson correlation block.
module tb_top;

    localparam int MAX_N     = 4096;
    localparam int CNT_BITS  = 13;
    localparam int WDOG_MAX  = 200000;
    localparam int RAND_ITEMS = 1350;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [15:0]   corr;
        pcs_pkg::status_t     st;
        logic [CNT_BITS-1:0]  cnt;
    } corr_res_t;

    typedef struct {
        int               x;
        int               y;
        bit               lastp;
        bit               typed;
        int               corr;
        pcs_pkg::status_t st;
        int               cnt;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pcs_pair_if   #(.SAMPLE_BITS(16))     pairs_if ();
    pcs_result_if #(.CNT_BITS(CNT_BITS))  res_if ();

    pearson_correlation_stream #(.MAX_PAIRS(MAX_N), .SAMPLE_BITS(16)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pairs  (pairs_if),
        .result (res_if)
    );

    // predictor state
    int unsigned        acc_n;
    logic signed [63:0] acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
    bit                 acc_ovf;

    corr_res_t exp_results[$];
    int        src_idle;
    int        snk_idle;
    int        mismatches;
    int        results_seen;
    int        pairs_sent;
    int        sets_sent;
    int        wdog;

    dir_row_t dir_tab[17] = '{
        '{0, 0, 1, 1, 0, pcs_pkg::ST_ZERO, 1},
        '{32767, 32767, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{-32768, -32768, 1, 1, 32767, pcs_pkg::ST_VALID, 2},
        '{32767, -32768, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{-32768, 32767, 1, 1, -32768, pcs_pkg::ST_VALID, 2},
        '{5, 1, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{5, 2, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{5, 3, 1, 1, 0, pcs_pkg::ST_ZERO, 3},
        '{1, 7, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{2, 7, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{3, 7, 1, 1, 0, pcs_pkg::ST_ZERO, 3},
        '{100, -3, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{-2000, 250, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{12345, -32768, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{-1, -1, 1, 0, 0, pcs_pkg::ST_VALID, 0},
        '{-32768, 32767, 0, 0, 0, pcs_pkg::ST_VALID, 0},
        '{21845, -21846, 1, 0, 0, pcs_pkg::ST_VALID, 0}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_sums();
        acc_n   = 0;
        acc_sx  = '0;
        acc_sy  = '0;
        acc_sxx = '0;
        acc_syy = '0;
        acc_sxy = '0;
        acc_ovf = 1'b0;
    endfunction

    // Full-scale signed sample as an int.
    function automatic int rand_sample();
        return int'($signed(16'($urandom)));
    endfunction

    // Accumulates one pair; returns 1 with the coefficient on a last pair.
    function automatic bit corr_predict(input logic signed [15:0] x, input logic signed [15:0] y,
                                        input logic lastp, output corr_res_t res);
        wide_t   n_w, sx_w, sy_w, va, vb, cv, mag, rhs, prod, t_w;
        longint  lo, hi, mid;
        if (acc_n < MAX_N)
        begin
            acc_sx  = acc_sx + 64'(x);
            acc_sy  = acc_sy + 64'(y);
            acc_sxx = acc_sxx + 64'(x) * 64'(x);
            acc_syy = acc_syy + 64'(y) * 64'(y);
            acc_sxy = acc_sxy + 64'(x) * 64'(y);
            acc_n++;
        end
        else
            acc_ovf = 1'b1;
        if (!lastp)
            return 0;
        res.corr = '0;
        res.st   = pcs_pkg::ST_VALID;
        res.cnt  = acc_n[CNT_BITS-1:0];
        if (acc_ovf)
            res.st = pcs_pkg::ST_OVF;
        else
        begin
            n_w  = wide_t'(acc_n);
            sx_w = wide_t'(acc_sx);
            sy_w = wide_t'(acc_sy);
            va = n_w * wide_t'(acc_sxx) - sx_w * sx_w;
            vb = n_w * wide_t'(acc_syy) - sy_w * sy_w;
            cv = n_w * wide_t'(acc_sxy) - sx_w * sy_w;
            if (acc_n == 0 || va <= 0 || vb <= 0)
                res.st = pcs_pkg::ST_ZERO;
            else
            begin
                mag  = (cv < 0) ? -cv : cv;
                rhs  = (mag * mag) <<< 32;
                prod = va * vb;
                lo = 0;
                hi = 32768;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    t_w = wide_t'(2 * mid - 1);
                    if (t_w * t_w * prod <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                if (cv < 0)
                    res.corr = 16'(-lo);
                else
                    res.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
            end
        end
        clear_sums();
        return 1;
    endfunction

    // One beat on the pair channel; typed expectation overrides the predictor.
    task automatic send_pair(input int x, input int y, input bit lastp,
                             input bit typed = 0,
                             input corr_res_t typed_res = '{0, pcs_pkg::ST_VALID, 0});
        corr_res_t res;
        bit        has_res;
        while ($urandom_range(99) < src_idle)
        begin
            pairs_if.valid <= 1'b0;
            @(posedge clk);
        end
        pairs_if.valid     <= 1'b1;
        pairs_if.x_value   <= 16'(x);
        pairs_if.y_value   <= 16'(y);
        pairs_if.last_pair <= lastp;
        @(posedge clk);
        while (!pairs_if.ready)
            @(posedge clk);
        has_res = corr_predict(16'(x), 16'(y), lastp, res);
        pairs_sent++;
        if (has_res)
        begin
            sets_sent++;
            exp_results.insert(exp_results.size(), typed ? typed_res : res);
        end
    endtask

    task automatic run_random(input int n_items);
        int sent, len, kind, x, y, cx, cy, amp, r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            len  = (r < 5) ? 1 : (r < 90) ? $urandom_range(30, 2) : $urandom_range(120, 31);
            kind = $urandom_range(5);
            amp  = $urandom_range(1) ? 32767 : $urandom_range(64, 1);
            cx = rand_sample();
            cy = rand_sample();
            for (int i = 0; i < len; i++)
            begin
                x = (amp == 32767) ? rand_sample() : $urandom_range(2 * amp) - amp;
                case (kind)
                    0, 1: y = (amp == 32767) ? rand_sample()
                                             : $urandom_range(2 * amp) - amp;
                    2: y = int'($signed(16'(x + $urandom_range(64) - 32)));
                    3: y = int'($signed(16'(~x)));
                    4: begin y = x; x = cx; end
                    default: y = cy;
                endcase
                send_pair(x, y, i == len - 1);
            end
            sent += len;
        end
    endtask

    always @(posedge clk)
    begin
        if (res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (exp_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: corr %0d status %0d count %0d",
                             res_if.correlation, res_if.status, res_if.pair_count);
            end
            else
            begin
                corr_res_t e;
                e = exp_results.pop_front();
                if (res_if.correlation !== e.corr || res_if.status !== e.st
                    || res_if.pair_count !== e.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp corr %0d status %0d count %0d, got %0d %0d %0d",
                                 e.corr, e.st, e.cnt, res_if.correlation, res_if.status,
                                 res_if.pair_count);
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if ((pairs_if.valid && pairs_if.ready) || (res_if.valid && res_if.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("watchdog: no beat for %0d cycles", WDOG_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        corr_res_t ovf_res;
        pairs_if.valid     = 1'b0;
        pairs_if.x_value   = '0;
        pairs_if.y_value   = '0;
        pairs_if.last_pair = 1'b0;
        res_if.ready       = 1'b0;
        rst_n        = 1'b0;
        wdog         = 0;
        mismatches   = 0;
        results_seen = 0;
        pairs_sent   = 0;
        sets_sent    = 0;
        src_idle     = 6;
        snk_idle     = 58;
        clear_sums();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_pair(dir_tab[i].x, dir_tab[i].y, dir_tab[i].lastp, dir_tab[i].typed,
                      '{16'(dir_tab[i].corr), dir_tab[i].st, CNT_BITS'(dir_tab[i].cnt)});

        run_random(RAND_ITEMS / 3);
        src_idle = 58;
        snk_idle = 6;
        run_random(RAND_ITEMS / 3);
        src_idle = 0;
        snk_idle = 0;
        run_random(RAND_ITEMS / 3);

        // one pair past the limit, then a normal set to show the sums cleared
        ovf_res = '{16'sd0, pcs_pkg::ST_OVF, CNT_BITS'(MAX_N)};
        for (int i = 0; i <= MAX_N; i++)
            send_pair(rand_sample(), rand_sample(), i == MAX_N, i == MAX_N, ovf_res);
        run_random(20);

        pairs_if.valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);

        $display("%0d pairs in %0d data sets, %0d results checked, %0d mismatches",
                 pairs_sent, sets_sent, results_seen, mismatches);
        $display("covered: full-scale and small samples, +/-1 extremes, zero variance, overflow");
        if (mismatches == 0 && exp_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/pcs_pkg.sv
hdl/pcs_if.sv
hdl/pearson_correlation_stream.sv
verif/tb_top.sv
